FILE: rtl/gmtm_pkg.sv
package gmtm_pkg;

  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLS    = 8;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
  localparam int M_W     = $clog2(MAX_ROWS + 1);
  localparam int N_W     = $clog2(MAX_COLS + 1);
  localparam int IDX_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int ACC_W      = 36;
  localparam int OUT_IDX_W  = 3;
  localparam int ROW_CFG_W  = 5;
  localparam int COL_CFG_W  = 4;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int OUT_DATA_W = 48;

  localparam logic [ROW_CFG_W-1:0] ROW_COUNT_RESET = ROW_CFG_W'(16);
  localparam logic [COL_CFG_W-1:0] COL_COUNT_RESET = COL_CFG_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_tag_t;

endpackage

FILE: rtl/gmtm_store.sv
module gmtm_store
  import gmtm_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [ELEM_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [ELEM_W-1:0] rdata_a_o,
  output logic [ELEM_W-1:0] rdata_b_o
);

  logic [ELEM_W-1:0] mem_q [STORE_DEPTH];
  logic [ELEM_W-1:0] rdata_a_q;
  logic [ELEM_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: rtl/gmtm_mac.sv
module gmtm_mac
  import gmtm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mac_tag_t          tag_i,
  input  logic [ELEM_W-1:0] a_i,
  input  logic [ELEM_W-1:0] b_i,
  input  logic              take_i,
  output logic              res_valid_o,
  output logic [ACC_W-1:0]  acc_o
);

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  mac_tag_t                 tag_q;
  logic [ACC_W-1:0]         prod_ext;
  logic [ACC_W-1:0]         acc_d;
  logic [ACC_W-1:0]         acc_q;
  logic                     res_valid_d;
  logic                     res_valid_q;

  assign prod_d   = PROD_W'($signed(a_i)) * PROD_W'($signed(b_i));
  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (tag_q.valid) begin
      acc_d = tag_q.first ? prod_ext : acc_q + prod_ext;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (take_i) begin
      res_valid_d = 1'b0;
    end
    if (tag_q.valid && tag_q.last) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      tag_q       <= tag_i;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign acc_o       = acc_q;

endmodule

FILE: rtl/gram_matrix_transpose_multiply.sv
// Gram matrix A^T * A of a signed 16-bit m-by-n matrix A.
// Input stream: one element per transfer, row-major, tdata[15:0]; taken at one
// transfer per cycle while the block is loading. Config: write row_count (index 0)
// or col_count (index 1) through cfg_we_i only while the block is idle.
// After the m*n-th element the block stops taking input and computes the n*n
// entries in row-major order with one multiply-accumulate unit fed by two read
// ports of the element store. Each entry is built from m reads of the store;
// the read data, the product and the running sum are registered in turn before
// the finished sum is taken into the output register.
// Output stream: tdata = value[35:0], row[38:36], col[41:39]; tlast marks the
// entry (n-1, n-1). Loading of the next matrix starts once the last entry is in
// the output register, so that transfer can overlap new input.
// When the receiver stalls, the output register holds and the sequencer waits
// with the finished sum. Reset clears the element counter, the sequencer and
// the output valid flag and restores row_count 16 and col_count 8; the element
// store is not cleared and needs no clearing pass.
module gram_matrix_transpose_multiply
  import gmtm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ELEM_W-1:0]     s_axis_tdata,   // [15:0] element
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [35:0] product_value, [38:36] out_row,
                                                // [41:39] out_col, [47:42] zero
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  state_e                 state_q, state_d;
  logic [ROW_CFG_W-1:0]   row_count_q;
  logic [COL_CFG_W-1:0]   col_count_q;
  logic [M_W-1:0]         m_w;
  logic [N_W-1:0]         n_w;
  logic [M_W-1:0]         m_last;
  logic [IDX_W-1:0]       n_last;
  logic [M_W+N_W-1:0]     total;

  logic [ADDR_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]       cnt_inc;
  logic [M_W-1:0]         k_q, k_d;
  logic [ADDR_W-1:0]      base_q, base_d;
  logic [IDX_W-1:0]       i_q, i_d;
  logic [IDX_W-1:0]       j_q, j_d;

  logic                   in_fire;
  logic                   load_done;
  logic                   entry_last;
  logic                   take;
  mac_tag_t               issue_tag;
  mac_tag_t               tag_q;

  logic [ELEM_W-1:0]      rdata_a;
  logic [ELEM_W-1:0]      rdata_b;
  logic                   res_valid;
  logic [ACC_W-1:0]       acc;

  logic                   out_valid_q;
  logic [ACC_W-1:0]       out_value_q;
  logic [OUT_IDX_W-1:0]   out_row_q;
  logic [OUT_IDX_W-1:0]   out_col_q;
  logic                   out_last_q;

  // clamp registers to their legal ranges
  always_comb begin
    if (row_count_q == '0) begin
      m_w = M_W'(1);
    end else if (32'(row_count_q) > MAX_ROWS) begin
      m_w = M_W'(MAX_ROWS);
    end else begin
      m_w = M_W'(row_count_q);
    end
    if (col_count_q == '0) begin
      n_w = N_W'(1);
    end else if (32'(col_count_q) > MAX_COLS) begin
      n_w = N_W'(MAX_COLS);
    end else begin
      n_w = N_W'(col_count_q);
    end
  end

  assign total      = (M_W+N_W)'(m_w) * (M_W+N_W)'(n_w);
  assign m_last     = m_w - M_W'(1);
  assign n_last     = IDX_W'(n_w - N_W'(1));
  assign cnt_inc    = CNT_W'(cnt_q) + CNT_W'(1);
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign load_done  = (32'(cnt_inc) >= 32'(total));
  assign entry_last = (i_q == n_last) && (j_q == n_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RESET;
      col_count_q <= COL_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_ROW_COUNT: row_count_q <= cfg_wdata_i[ROW_CFG_W-1:0];
        CFG_COL_COUNT: col_count_q <= cfg_wdata_i[COL_CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire && load_done) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (k_q == m_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (take) state_d = entry_last ? ST_LOAD : ST_RUN;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    issue_tag     = '0;
    take          = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
      end
      ST_RUN: begin
        issue_tag.valid = 1'b1;
        issue_tag.first = (k_q == '0);
        issue_tag.last  = (k_q == m_last);
      end
      ST_DRAIN: begin
        take = res_valid && (!out_valid_q || m_axis_tready);
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // sequencer counters
  always_comb begin
    cnt_d  = cnt_q;
    k_d    = k_q;
    base_d = base_q;
    i_d    = i_q;
    j_d    = j_q;
    if (in_fire) begin
      cnt_d  = load_done ? '0 : cnt_inc[ADDR_W-1:0];
      k_d    = '0;
      base_d = '0;
      i_d    = '0;
      j_d    = '0;
    end
    if (issue_tag.valid && !issue_tag.last) begin
      k_d    = k_q + M_W'(1);
      base_d = base_q + ADDR_W'(n_w);
    end
    if (take) begin
      k_d    = '0;
      base_d = '0;
      if (j_q == n_last) begin
        j_d = '0;
        i_d = i_q + IDX_W'(1);
      end else begin
        j_d = j_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      k_q     <= '0;
      base_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      tag_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      base_q  <= base_d;
      i_q     <= i_d;
      j_q     <= j_d;
      tag_q   <= issue_tag;
    end
  end

  gmtm_store u_store (
    .clk_i     (clk_i),
    .we_i      (in_fire),
    .waddr_i   (cnt_q),
    .wdata_i   (s_axis_tdata),
    .raddr_a_i (base_q + ADDR_W'(i_q)),
    .raddr_b_i (base_q + ADDR_W'(j_q)),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  gmtm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag_q),
    .a_i         (rdata_a),
    .b_i         (rdata_b),
    .take_i      (take),
    .res_valid_o (res_valid),
    .acc_o       (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_value_q <= acc;
      out_row_q   <= OUT_IDX_W'(i_q);
      out_col_q   <= OUT_IDX_W'(j_q);
      out_last_q  <= entry_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - ACC_W - 2 * OUT_IDX_W){1'b0}},
                          out_col_q, out_row_q, out_value_q};
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/gmtm_checker.sv
module gmtm_checker
  import gmtm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  localparam int ROW_LO = ACC_W;
  localparam int COL_LO = ACC_W + OUT_IDX_W;

  // output register is empty while reset is held
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result pending during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // no new elements while a non-final result entry is pending
  a_no_load_mid_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken during result emission");

  // final entry sits on the diagonal
  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata[ROW_LO+OUT_IDX_W-1:ROW_LO] == m_axis_tdata[COL_LO+OUT_IDX_W-1:COL_LO])
    else $error("last entry off the diagonal");

endmodule

bind gram_matrix_transpose_multiply gmtm_checker u_checker (.*);
